// File: src/ckb_pkg.sv
package ckb_pkg;

    // Register map (word index = paddr[3:2])
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_KEY_CB     = 2'd0;
    localparam logic [1:0] REG_KEY_CR     = 2'd1;
    localparam logic [1:0] REG_ACCEPT_TAN = 2'd2;
    localparam logic [1:0] REG_BLEND_MODE = 2'd3;

    // Blend formulas
    localparam logic [2:0] BL_LIGHT_DIFF = 3'd0;
    localparam logic [2:0] BL_COLOR_BURN = 3'd1;
    localparam logic [2:0] BL_MULTIPLY   = 3'd2;
    localparam logic [2:0] BL_REFLECT    = 3'd3;
    localparam logic [2:0] BL_DIVIDE     = 3'd4;
    localparam logic [2:0] BL_LIN_LIGHT  = 3'd5;
    localparam logic [2:0] BL_SUBTRACT   = 3'd6;
    localparam logic [2:0] BL_OVERLAY    = 3'd7;

    localparam logic [7:0] LUMA_MIN = 8'd16;
    localparam logic [7:0] LUMA_MAX = 8'd235;

    // Divider: 16-bit dividend, 8-bit divisor, DIV_STEPS quotient bits per stage
    localparam int DIV_W      = 16;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;
    localparam int PIPE_DEPTH = DIV_STAGES + 1;

    typedef struct packed {
        logic signed [7:0] key_cb;
        logic signed [7:0] key_cr;
        logic [12:0]       accept_tan;
        logic [2:0]        blend_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       rem;
        logic [DIV_W-1:0] num;  // dividend bits shift out on top, quotient bits shift in below
        logic [7:0]       dvs;
    } div_t;

    typedef struct packed {
        logic [7:0] fg_luma;
        logic [7:0] bg_luma;
        logic       frame_end;
    } side_t;

    function automatic logic [7:0] clamp_luma(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (v < LUMA_MIN)
            r = LUMA_MIN;
        else if (v > LUMA_MAX)
            r = LUMA_MAX;
        return r;
    endfunction

    // Final blend from the luma pair, the stage product and the quotient
    function automatic logic [7:0] blend_final(
        input logic [2:0]       mode,
        input logic [7:0]       a,
        input logic [7:0]       b,
        input logic [15:0]      prod,
        input logic [DIV_W-1:0] quo
    );
        logic [8:0] s;
        logic [8:0] t;
        logic [7:0] v;
        logic [7:0] r;
        s = {1'b0, a} + {1'b0, b};
        t = '0;
        v = '0;
        r = '0;
        case (mode)
            BL_LIGHT_DIFF: begin
                t = (s <= 9'd255) ? s : (9'd510 - s);
                r = t[7:0];
            end
            BL_COLOR_BURN: begin
                v = 8'd255 - quo[7:0];
                r = clamp_luma(v);
            end
            BL_MULTIPLY: r = prod[15:8];
            BL_REFLECT: begin
                v = quo[7:0];
                r = (v < LUMA_MIN || v > LUMA_MAX) ? a : v;
            end
            BL_DIVIDE: r = clamp_luma(quo[7:0]);
            BL_LIN_LIGHT: begin
                // a + 2b - 235, wrapped to 8 bits (-235 == +21 mod 256)
                v = a + {b[6:0], 1'b0} + 8'd21;
                r = clamp_luma(v);
            end
            BL_SUBTRACT: r = a + b + 8'd1;
            default: begin
                t = b[7] ? (9'd255 - prod[15:7]) : prod[15:7];
                r = (t < {1'b0, LUMA_MIN}) ? LUMA_MIN : t[7:0];
            end
        endcase
        return r;
    endfunction

endpackage

// File: src/ckb_ifs.sv
interface ckb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] fg_luma;
    logic [7:0] fg_blue_diff;
    logic [7:0] fg_red_diff;
    logic [7:0] bg_luma;
    logic       frame_end;

    modport source (
        output valid, fg_luma, fg_blue_diff, fg_red_diff, bg_luma, frame_end,
        input  ready
    );
    modport sink (
        input  valid, fg_luma, fg_blue_diff, fg_red_diff, bg_luma, frame_end,
        output ready
    );
endinterface

interface ckb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_luma;
    logic       keyed;
    logic       frame_end_out;

    modport source (
        output valid, out_luma, keyed, frame_end_out,
        input  ready
    );
    modport sink (
        input  valid, out_luma, keyed, frame_end_out,
        output ready
    );
endinterface

// File: src/ckb_cfg.sv
module ckb_cfg import ckb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_cb     <= '0;
            cfg_reg.key_cr     <= '0;
            cfg_reg.accept_tan <= '0;
            cfg_reg.blend_mode <= BL_COLOR_BURN;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_KEY_CB:     cfg_reg.key_cb     <= pwdata[7:0];
                REG_KEY_CR:     cfg_reg.key_cr     <= pwdata[7:0];
                REG_ACCEPT_TAN: cfg_reg.accept_tan <= pwdata[12:0];
                REG_BLEND_MODE: cfg_reg.blend_mode <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_KEY_CB:     prdata = {{24{cfg_reg.key_cb[7]}}, cfg_reg.key_cb};
            REG_KEY_CR:     prdata = {{24{cfg_reg.key_cr[7]}}, cfg_reg.key_cr};
            REG_ACCEPT_TAN: prdata = {19'd0, cfg_reg.accept_tan};
            REG_BLEND_MODE: prdata = {29'd0, cfg_reg.blend_mode};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: src/ckb_key.sv
module ckb_key import ckb_pkg::*; (
    input  logic       clk,
    input  logic       adv,
    input  cfg_t       cfg,
    input  logic [7:0] fg_blue_diff,
    input  logic [7:0] fg_red_diff,
    output logic       hit
);

    // Stage A: four chroma products
    logic signed [16:0] cb_kcb_reg, cr_kcr_reg, cr_kcb_reg, cb_kcr_reg;
    // Stage B: rotated, saturated coordinates
    logic signed [17:0] sum_x, sum_y;
    logic signed [7:0]  xx_reg, yy_reg;
    // Stage C: limit product and |yy|
    logic signed [21:0] lim_prod_reg;
    logic [7:0]         ay_reg;
    // Stage D: compare
    logic [7:0]         lim8, lim;
    logic               hit_reg;

    function automatic logic signed [7:0] sat_s8(input logic signed [10:0] v);
        logic signed [7:0] r;
        r = v[7:0];
        if (v < -11'sd128)
            r = -8'sd128;
        else if (v > 11'sd127)
            r = 8'sd127;
        return r;
    endfunction

    assign sum_x = 18'(cb_kcb_reg) + 18'(cr_kcr_reg);
    assign sum_y = 18'(cr_kcb_reg) - 18'(cb_kcr_reg);

    // Low byte of the arithmetic shift by 4, capped at 127
    assign lim8 = lim_prod_reg[11:4];
    assign lim  = lim8[7] ? 8'd127 : lim8;
    assign hit  = hit_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cb_kcb_reg <= 17'($signed({1'b0, fg_blue_diff}) * cfg.key_cb);
            cr_kcr_reg <= 17'($signed({1'b0, fg_red_diff}) * cfg.key_cr);
            cr_kcb_reg <= 17'($signed({1'b0, fg_red_diff}) * cfg.key_cb);
            cb_kcr_reg <= 17'($signed({1'b0, fg_blue_diff}) * cfg.key_cr);

            xx_reg <= sat_s8(sum_x[17:7]);
            yy_reg <= sat_s8(sum_y[17:7]);

            lim_prod_reg <= 22'(xx_reg * $signed({1'b0, cfg.accept_tan}));
            ay_reg       <= yy_reg[7] ? 8'(-yy_reg) : 8'(yy_reg);

            hit_reg <= ay_reg < lim;
        end
    end

endmodule

// File: src/ckb_blend.sv
module ckb_blend import ckb_pkg::*; (
    input  logic        clk,
    input  logic        adv,
    input  logic [2:0]  mode,
    input  logic [7:0]  fg_luma,
    input  logic [7:0]  bg_luma,
    output logic [15:0] prod,
    output div_t        div_init
);

    logic [7:0]  mul_x, mul_y, dvs;
    logic [7:0]  a_lo, b_lo, b_hi, inv_b;
    logic [15:0] prod_reg;
    logic [7:0]  dvs_reg;

    assign a_lo  = (fg_luma < LUMA_MIN) ? LUMA_MIN : fg_luma;
    assign b_lo  = (bg_luma < LUMA_MIN) ? LUMA_MIN : bg_luma;
    assign b_hi  = (bg_luma > LUMA_MAX) ? LUMA_MAX : bg_luma;
    assign inv_b = 8'd255 - bg_luma;

    // One shared multiplier; the dividing modes also set the divisor
    always_comb
    begin
        mul_x = fg_luma;
        mul_y = bg_luma;
        dvs   = 8'd1;
        case (mode)
            BL_COLOR_BURN: begin
                mul_x = 8'd255 - b_lo;
                mul_y = 8'd255 - b_lo;
                dvs   = a_lo;
            end
            BL_REFLECT: begin
                mul_x = fg_luma;
                mul_y = fg_luma;
                dvs   = 8'd255 - b_hi;
            end
            BL_DIVIDE: begin
                mul_x = bg_luma;
                mul_y = 8'd1;
                dvs   = (inv_b < LUMA_MIN) ? LUMA_MIN : inv_b;
            end
            BL_OVERLAY: begin
                if (bg_luma[7])
                begin
                    mul_x = inv_b;
                    mul_y = 8'd255 - fg_luma;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= mul_x * mul_y;
            dvs_reg  <= dvs;
        end
    end

    assign prod          = prod_reg;
    assign div_init.rem  = '0;
    assign div_init.num  = prod_reg;
    assign div_init.dvs  = dvs_reg;

endmodule

// File: src/ckb_div_stage.sv
module ckb_div_stage import ckb_pkg::*; (
    input  logic clk,
    input  logic adv,
    input  div_t d_in,
    output div_t d_out
);

    div_t       w;
    logic [8:0] r9;
    logic [8:0] diff;
    logic       ge;
    div_t       d_reg;

    // Restoring division, DIV_STEPS quotient bits
    always_comb
    begin
        w    = d_in;
        r9   = '0;
        diff = '0;
        ge   = 1'b0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r9    = {w.rem, w.num[DIV_W-1]};
            diff  = r9 - {1'b0, w.dvs};
            ge    = r9 >= {1'b0, w.dvs};
            w.rem = ge ? diff[7:0] : r9[7:0];
            w.num = {w.num[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= w;
    end

    assign d_out = d_reg;

endmodule

// File: src/chroma_key_select_blend.sv
// Chroma key test with luma blend, one pixel word per clock.
//
// in_ch carries a foreground Y/Cb/Cr pixel, the background Y and a
// frame end mark; out_ch returns the resulting luma, the keyed flag and
// the frame end mark, one result word for each input word, in order.
// The user must write key direction, acceptance tangent and blend mode
// over APB only while no pixel is in flight; the block does not enforce it.
//
// A result word passes five pipeline stages (chroma products, rotation
// and limit math, then a four-stage restoring divider running beside
// them at 4 quotient bits per stage) and the output register.
// Throughput: one word per cycle while out_ch does not stall.
//
// When out_ch stalls with a word waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated. Reset empties every
// stage and loads the registers with key 0/0, tangent 0, blend mode 1.
module chroma_key_select_blend import ckb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    ckb_in_if.sink            in_ch,
    ckb_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t cfg;
    logic adv;

    // Valid bits of the five inner stages plus the output register
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  out_valid_reg;

    // Side payload carried along the stages
    side_t       side_reg [0:PIPE_DEPTH-1];
    logic [15:0] prod_a;
    logic [15:0] prod_reg [1:PIPE_DEPTH-1];
    div_t        div_pipe [0:DIV_STAGES];
    logic        hit_d;
    logic        hit_e_reg;

    logic [7:0]  out_luma_reg;
    logic        keyed_reg;
    logic        frame_end_out_reg;

    // Advance every stage when the output register is empty or being drained
    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    ckb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Key test: products, rotate and saturate, limit, compare (hit at stage D)
    ckb_key u_key (
        .clk          (clk),
        .adv          (adv),
        .cfg          (cfg),
        .fg_blue_diff (in_ch.fg_blue_diff),
        .fg_red_diff  (in_ch.fg_red_diff),
        .hit          (hit_d)
    );

    // Blend operand product and divider setup (stage A)
    ckb_blend u_blend (
        .clk      (clk),
        .adv      (adv),
        .mode     (cfg.blend_mode),
        .fg_luma  (in_ch.fg_luma),
        .bg_luma  (in_ch.bg_luma),
        .prod     (prod_a),
        .div_init (div_pipe[0])
    );

    // Divider stages B..E
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        ckb_div_stage u_div (
            .clk   (clk),
            .adv   (adv),
            .d_in  (div_pipe[k]),
            .d_out (div_pipe[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[PIPE_DEPTH-2:0], in_ch.valid};
            out_valid_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].fg_luma   <= in_ch.fg_luma;
            side_reg[0].bg_luma   <= in_ch.bg_luma;
            side_reg[0].frame_end <= in_ch.frame_end;
            for (int i = 1; i < PIPE_DEPTH; i++)
                side_reg[i] <= side_reg[i-1];

            prod_reg[1] <= prod_a;
            for (int i = 2; i < PIPE_DEPTH; i++)
                prod_reg[i] <= prod_reg[i-1];

            hit_e_reg <= hit_d;

            // Output register: blend when keyed, else pass the foreground luma
            out_luma_reg <= hit_e_reg
                ? blend_final(cfg.blend_mode,
                              side_reg[PIPE_DEPTH-1].fg_luma,
                              side_reg[PIPE_DEPTH-1].bg_luma,
                              prod_reg[PIPE_DEPTH-1],
                              div_pipe[DIV_STAGES].num)
                : side_reg[PIPE_DEPTH-1].fg_luma;
            keyed_reg         <= hit_e_reg;
            frame_end_out_reg <= side_reg[PIPE_DEPTH-1].frame_end;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_luma      = out_luma_reg;
    assign out_ch.keyed         = keyed_reg;
    assign out_ch.frame_end_out = frame_end_out_reg;

endmodule

// File: tb/sv/ckb_luma_checker.sv
`timescale 1ns / 100ps

module ckb_luma_checker import ckb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    ckb_in_if                 pix_in,
    ckb_out_if                pix_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic [7:0] out_luma;
        logic       keyed;
        logic       frame_end_out;
    } luma_result_t;

    cfg_t         key_cfg;
    luma_result_t pending_pixels[$];
    int           results_seen;

    initial begin
        errors       = 0;
        pending      = 0;
        results_seen = 0;
    end

    function automatic int clamp_chroma(input int v);
        if (v < -128)
            return -128;
        if (v > 127)
            return 127;
        return v;
    endfunction

    function automatic int clamp_y(input int v);
        if (v < int'(LUMA_MIN))
            return int'(LUMA_MIN);
        if (v > int'(LUMA_MAX))
            return int'(LUMA_MAX);
        return v;
    endfunction

    function automatic logic [7:0] luma_blend(input logic [2:0] mode, input int a, input int b);
        int t;
        int v;
        int c;
        v = 0;
        case (mode)
            BL_LIGHT_DIFF: begin
                t = 255 - a - b;
                if (t < 0)
                    t = -t;
                v = (255 - t) & 255;
            end
            BL_COLOR_BURN: begin
                if (a < 16)
                    a = 16;
                if (b < 16)
                    b = 16;
                v = clamp_y((255 - ((255 - b) * (255 - b)) / a) & 255);
            end
            BL_MULTIPLY: v = (a * b) >> 8;
            BL_REFLECT: begin
                if (b > 235)
                    b = 235;
                v = ((a * a) / (255 - b)) & 255;
                if (v < 16 || v > 235)
                    v = a;
            end
            BL_DIVIDE: begin
                c = 255 - b;
                if (c < 16)
                    c = 16;
                v = clamp_y(b / c);
            end
            BL_LIN_LIGHT: v = clamp_y((a + 2 * b - 235) & 255);
            BL_SUBTRACT:  v = (a + b - 255) & 255;
            default: begin
                if (b < 128)
                    v = (a * b) >> 7;
                else
                    v = 255 - (((255 - b) * (255 - a)) >> 7);
                if (v < 16)
                    v = 16;
                v = v & 255;
            end
        endcase
        return v[7:0];
    endfunction

    // Rotate chroma onto the key axis, test the angle, pick blended or plain luma.
    function automatic luma_result_t predict_pixel(input cfg_t c, input logic [7:0] fy,
                                                   input logic [7:0] cb, input logic [7:0] cr,
                                                   input logic [7:0] by, input logic fe);
        int kcb;
        int kcr;
        int xx;
        int yy;
        int lim;
        int ay;
        luma_result_t r;
        kcb = int'($signed(c.key_cb));
        kcr = int'($signed(c.key_cr));
        xx  = clamp_chroma((int'(cb) * kcb + int'(cr) * kcr) >>> 7);
        yy  = clamp_chroma((int'(cr) * kcb - int'(cb) * kcr) >>> 7);
        // keep the low byte of the limit, even when the product is negative
        lim = ((xx * int'(c.accept_tan)) >>> 4) & 255;
        if (lim > 127)
            lim = 127;
        ay = (yy < 0) ? -yy : yy;
        r.keyed         = (ay < lim);
        r.out_luma      = r.keyed ? luma_blend(c.blend_mode, int'(fy), int'(by)) : fy;
        r.frame_end_out = fe;
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        $display("result word %0d: %s", results_seen, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        luma_result_t want;
        if (!rst_n) begin
            key_cfg.key_cb     = '0;
            key_cfg.key_cr     = '0;
            key_cfg.accept_tan = '0;
            key_cfg.blend_mode = BL_COLOR_BURN;
            pending_pixels.delete();
            pending = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_KEY_CB:     key_cfg.key_cb     = pwdata[7:0];
                    REG_KEY_CR:     key_cfg.key_cr     = pwdata[7:0];
                    REG_ACCEPT_TAN: key_cfg.accept_tan = pwdata[12:0];
                    REG_BLEND_MODE: key_cfg.blend_mode = pwdata[2:0];
                    default: ;
                endcase
            end
            if (pix_out.valid && pix_out.ready) begin
                if (pending_pixels.size() == 0) begin
                    note_mismatch("result word with nothing pending");
                end else begin
                    want = pending_pixels.pop_front();
                    if (pix_out.out_luma !== want.out_luma)
                        note_mismatch($sformatf("out_luma %0d, expected %0d",
                                                pix_out.out_luma, want.out_luma));
                    if (pix_out.keyed !== want.keyed)
                        note_mismatch($sformatf("keyed %0b, expected %0b",
                                                pix_out.keyed, want.keyed));
                    if (pix_out.frame_end_out !== want.frame_end_out)
                        note_mismatch($sformatf("frame_end_out %0b, expected %0b",
                                                pix_out.frame_end_out, want.frame_end_out));
                end
                results_seen++;
            end
            if (pix_in.valid && pix_in.ready)
                pending_pixels.push_back(predict_pixel(key_cfg, pix_in.fg_luma,
                                                       pix_in.fg_blue_diff, pix_in.fg_red_diff,
                                                       pix_in.bg_luma, pix_in.frame_end));
            pending = pending_pixels.size();
        end
    end

endmodule

// File: tb/sv/chroma_key_select_blend_test.sv
`timescale 1ns / 100ps

module chroma_key_select_blend_test;
    import ckb_pkg::*;

    // Hang guard for the whole run; take plenty of margin.
    localparam int CYCLE_LIMIT       = 200000;
    localparam int DRAIN_CYCLES      = 20;   // pipeline is 6 deep, leave room for strays
    localparam int HOLD_CYCLES       = 300;  // long receiver hold-off
    localparam int ITEMS_PER_SETTING = 50;
    localparam int SETTINGS_PER_PHASE = 7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int errors;
    int pending;
    int cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_requests = 0;

    // current key direction, used to aim pixels at the key region
    logic signed [7:0] cur_kcb = '0;
    logic signed [7:0] cur_kcr = '0;

    ckb_in_if  pix_in();
    ckb_out_if pix_out();

    chroma_key_select_blend dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (pix_in),
        .out_ch  (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Watch both channels and the register port, predict each word and compare.
    ckb_luma_checker luma_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Guard against a hung pipeline or a lost word.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: drop ready at random, and serve each hold-off request with a
    // long stretch of ready low while the sender keeps offering words.
    initial
    begin
        int stall_left;
        int served;
        stall_left = 0;
        served = 0;
        pix_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && served != hold_requests)
            begin
                served = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                pix_out.ready <= 1'b0;
                stall_left--;
            end
            else
                pix_out.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Offer one pixel word; return at the falling edge after it is taken,
    // with valid still high so a following word goes out back to back.
    task automatic send_pixel(input logic [7:0] fy, input logic [7:0] cb, input logic [7:0] cr,
                              input logic [7:0] by, input logic fe);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid        <= 1'b1;
        pix_in.fg_luma      <= fy;
        pix_in.fg_blue_diff <= cb;
        pix_in.fg_red_diff  <= cr;
        pix_in.bg_luma      <= by;
        pix_in.frame_end    <= fe;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering words and hold until every pending result has come back.
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Setup and access cycle, then psel and penable drop and stay low until
    // the task returns, so back-to-back writes never drive psel twice in the same step.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Registers change only with the pipeline empty.
    task automatic load_setting(input logic signed [7:0] kcb, input logic signed [7:0] kcr,
                                input logic [12:0] tan, input logic [2:0] mode);
        wait_idle();
        apb_write(REG_KEY_CB, {24'd0, kcb});
        apb_write(REG_KEY_CR, {24'd0, kcr});
        apb_write(REG_ACCEPT_TAN, {19'd0, tan});
        apb_write(REG_BLEND_MODE, {29'd0, mode});
        cur_kcb = kcb;
        cur_kcr = kcr;
    endtask

    // Pick a setting for random slot s; every few slots lands on an extreme.
    task automatic random_setting(input int s);
        logic signed [7:0] kcb;
        logic signed [7:0] kcr;
        logic [12:0]       tan;
        case (s % 5)
            0:
            begin
                kcb = 8'sd127;
                kcr = 8'sd0;
                tan = 13'h1FFF;
            end
            1:
            begin
                kcb = -8'sd128;
                kcr = -8'sd127;
                tan = 13'($urandom_range(8191));
            end
            2:
            begin
                kcb = 8'sd0;
                kcr = 8'sd127;
                tan = 13'($urandom_range(255));
            end
            3:
            begin
                kcb = 8'($urandom_range(127));
                kcr = 8'($urandom_range(127));
                tan = 13'($urandom_range(8191));
            end
            default:
            begin
                kcb = 8'($urandom);
                kcr = 8'($urandom);
                tan = 13'($urandom);
            end
        endcase
        load_setting(kcb, kcr, tan, 3'(s % 8));
    endtask

    // Chroma byte near t along key component k, with a little jitter.
    function automatic logic [7:0] aim_chroma(input int k, input int t);
        int v;
        v = k * t / 127 + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // Most pixels point along the key so the angle test is exercised;
    // the rest are arbitrary chroma.
    task automatic random_pixel();
        logic [7:0] fy;
        logic [7:0] by;
        logic [7:0] cb;
        logic [7:0] cr;
        int         t;
        fy = 8'($urandom);
        by = 8'($urandom);
        if ($urandom_range(15) == 0)
            fy = 8'd0;
        if ($urandom_range(15) == 0)
            by = 8'hFF;
        if ($urandom_range(99) < 65)
        begin
            t  = $urandom_range(255);
            cb = aim_chroma(int'(cur_kcb), t);
            cr = aim_chroma(int'(cur_kcr), t);
        end
        else
        begin
            cb = 8'($urandom);
            cr = 8'($urandom);
        end
        send_pixel(fy, cb, cr, by, $urandom_range(7) == 0);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pix_in.valid        = 1'b0;
        pix_in.fg_luma      = '0;
        pix_in.fg_blue_diff = '0;
        pix_in.fg_red_diff  = '0;
        pix_in.bg_luma      = '0;
        pix_in.frame_end    = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct = 23;
        snk_idle_pct = 54;

        // Reset setting: zero tangent, so nothing may key.
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'd16, 8'd128, 8'd128, 8'd235, 1'b0);
        send_pixel(8'd235, 8'hFF, 8'd0, 8'd16, 1'b1);

        // Key along Cb with the widest angle: pixels with Cb high and Cr low
        // key, so each blend formula sees the luma extremes.
        for (int m = int'(BL_LIGHT_DIFF); m <= int'(BL_OVERLAY); m++)
        begin
            load_setting(8'sd127, 8'sd0, 13'h1FFF, 3'(m));
            send_pixel(8'd0, 8'hFF, 8'd0, 8'hFF, 1'b0);
            send_pixel(8'hFF, 8'hFF, 8'd0, 8'd0, 1'b1);
        end

        // Out-of-range key components: the limit product goes negative and
        // its wrapped low byte is what remains; one pixel inside, one far out.
        load_setting(-8'sd128, -8'sd128, 13'h1FFF, BL_OVERLAY);
        send_pixel(8'd200, 8'hFF, 8'd250, 8'd100, 1'b0);
        send_pixel(8'd100, 8'd0, 8'hFF, 8'd30, 1'b1);

        // Random part: three idle patterns, several settings in each.
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 54 : 0;
            snk_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 23 : 0;
            for (int k = 0; k < SETTINGS_PER_PHASE; k++)
            begin
                random_setting(ph * SETTINGS_PER_PHASE + k);
                // once: stall the receiver long enough to fill the pipeline
                if (ph == 0 && k == 1)
                    hold_requests++;
                repeat (ITEMS_PER_SETTING)
                    random_pixel();
            end
        end

        // Drain, then allow a few more cycles for any stray word.
        wait_idle();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
